// File: hdl/swm_pkg.sv
package swm_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 32;
	localparam int CFG_W       = 7;
	localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] RESET_WINDOW = CFG_W'(3);

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic             en;
		sample_t          sample;
		logic             full;
		logic [IDX_W-1:0] oldest_age;
	} swm_bcast_t;

	typedef struct packed {
		sample_t          value;
		logic [IDX_W-1:0] age;
		logic             lt;
		logic             rm;
		logic             lu;
	} swm_link_t;

	function automatic logic [CNT_W-1:0] clamp_window(input logic [CFG_W-1:0] ws);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(ws);
		if (wide == '0) begin
			return CNT_W'(1);
		end else if (wide > CMP_W'(MAX_WINDOW)) begin
			return CNT_W'(MAX_WINDOW);
		end else begin
			return CNT_W'(wide);
		end
	endfunction

endpackage

// File: hdl/swm_cell.sv
module swm_cell (
	input  logic              clk,
	input  swm_pkg::swm_bcast_t bc,
	input  logic              occ,
	input  logic              below,
	input  logic              below_lo,
	input  swm_pkg::swm_link_t lo,
	input  swm_pkg::swm_link_t hi,
	output swm_pkg::swm_link_t me
);
	import swm_pkg::*;

	sample_t          value_q;
	logic [IDX_W-1:0] age_q;
	logic             lt;
	logic             lu;

	// Each cell is one slot of the sorted window. On a transfer, the oldest slot
	// leaves, the slots above it move down, and the new sample is slid in.
	assign lt = !occ || ($signed(bc.sample) < $signed(value_q));
	assign lu = below ? hi.lt : lt;

	assign me.value = value_q;
	assign me.age   = age_q;
	assign me.lt    = lt;
	assign me.rm    = occ && bc.full && (age_q == bc.oldest_age);
	assign me.lu    = lu;

	always_ff @(posedge clk) begin
		if (bc.en) begin
			if (!lu) begin
				value_q <= below ? hi.value : value_q;
				age_q   <= (below ? hi.age : age_q) + 1'b1;
			end else if (!lo.lu) begin
				value_q <= bc.sample;
				age_q   <= '0;
			end else begin
				value_q <= below_lo ? value_q : lo.value;
				age_q   <= (below_lo ? age_q : lo.age) + 1'b1;
			end
		end
	end

endmodule

// File: hdl/sliding_window_median.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   sample
// output    out        out_valid / out_stall median
// config    in         cfg_we                cfg_wdata (window size)
//
// One sample is taken every cycle while in_stall is low; the row of sorting cells inserts it and
// drops the oldest entry in the cycle of its transfer.
// The median leaves through the cell update and then the selection into the
// output register; an output stall can hold it between the two.
// Reset clears the fill count and sets the window size to three.
// A stalled output holds its result and stalls the input only when a second
// result is waiting behind it.
module sliding_window_median (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [swm_pkg::SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [swm_pkg::SAMPLE_BITS-1:0] median
);
	import swm_pkg::*;

	logic [CNT_W-1:0] weff_q;
	logic [IDX_W-1:0] oldest_q;
	logic [IDX_W-1:0] med_idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] w_new;
	logic             res_s1;
	logic             out_valid_q;
	sample_t          median_q;
	logic             accept;
	logic             load;
	swm_bcast_t       bc;
	swm_link_t        links [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] rm_vec;
	logic [MAX_WINDOW-1:0] below_vec;
	sample_t          cell_val [MAX_WINDOW];

	assign w_new   = clamp_window(cfg_wdata);
	assign cnt_inc = (cnt_q == weff_q) ? cnt_q : cnt_q + 1'b1;

	assign load     = res_s1 && (!out_valid_q || !out_stall);
	assign in_stall = res_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign bc.en         = accept;
	assign bc.sample     = sample;
	assign bc.full       = (cnt_q == weff_q);
	assign bc.oldest_age = oldest_q;

	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		localparam logic [MAX_WINDOW-1:0] MASK = {MAX_WINDOW{1'b1}} >> (MAX_WINDOW - 1 - j);
		swm_link_t lo_link;
		swm_link_t hi_link;
		logic      below_lo;

		assign rm_vec[j]    = links[j].rm;
		assign below_vec[j] = |(rm_vec & MASK);
		assign cell_val[j]  = links[j].value;

		if (j == 0) begin : g_first
			assign lo_link  = '0;
			assign below_lo = 1'b0;
		end else begin : g_mid_lo
			assign lo_link  = links[j-1];
			assign below_lo = below_vec[j-1];
		end

		if (j == MAX_WINDOW - 1) begin : g_last
			always_comb begin
				hi_link    = '0;
				hi_link.lt = 1'b1;
			end
		end else begin : g_mid_hi
			assign hi_link = links[j+1];
		end

		swm_cell u_cell (
			.clk      (clk),
			.bc       (bc),
			.occ      (CNT_W'(j) < cnt_q),
			.below    (below_vec[j]),
			.below_lo (below_lo),
			.lo       (lo_link),
			.hi       (hi_link),
			.me       (links[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weff_q      <= clamp_window(RESET_WINDOW);
			oldest_q    <= IDX_W'(clamp_window(RESET_WINDOW) - 1'b1);
			med_idx_q   <= IDX_W'((clamp_window(RESET_WINDOW) - 1'b1) >> 1);
			cnt_q       <= '0;
			res_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				weff_q    <= w_new;
				oldest_q  <= IDX_W'(w_new - 1'b1);
				med_idx_q <= IDX_W'((w_new - 1'b1) >> 1);
				cnt_q     <= '0;
			end else if (accept) begin
				cnt_q <= cnt_inc;
			end
			if (accept) begin
				res_s1 <= (cnt_inc == weff_q);
			end else if (load) begin
				res_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			median_q <= cell_val[med_idx_q];
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= weff_q)
		else $error("fill count exceeds window");

	a_res_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1 && !cfg_we |-> cnt_q == weff_q)
		else $error("result pending with window not full");

	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		bc.full |-> $onehot(rm_vec))
		else $error("full window must have exactly one oldest cell");

	a_no_rm_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!bc.full |-> rm_vec == '0)
		else $error("removal while window is filling");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(median_q))
		else $error("stalled result changed");

endmodule
